/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks shared by the peak/phase-vocoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define SPVP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequent holds on the edge after the antecedent
`define SPVP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/spvp_pkg.sv */
// ----------------------------------------------------------------------------
// spvp_pkg
// Types and constants for the spectral peak phase-vocoder pitch estimator.
// ----------------------------------------------------------------------------
package spvp_pkg;

    localparam int XFORM_LEN_DEF = 1024;
    localparam int FIFO_DEPTH    = 2;

    localparam int MAG_W     = 32;
    localparam int PHASE_W   = 16;
    localparam int PEAK_BIN_W = 9;
    localparam int COARSE_W  = 25;
    localparam int REF_W     = 24;
    localparam int TURN_W    = 6;
    localparam int D15_W     = PHASE_W + 1;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CNT_CFG_W = 7;

    // estimate = (d15 + k*2^15) * hop, signed
    localparam int EST_W = 41;
    localparam int RND_W = EST_W - 15;

    localparam logic signed [RND_W-1:0] REF_MIN = RND_W'(-65536);
    localparam logic signed [RND_W-1:0] REF_MAX = RND_W'(4259775);

    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOP_RATE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAND_CNT  = 2'd2;

    localparam logic [CFG_W-1:0]     BIN_WIDTH_RST = 16'd10000;
    localparam logic [CFG_W-1:0]     HOP_RATE_RST  = 16'd10000;
    localparam logic [CNT_CFG_W-1:0] CAND_CNT_RST  = 7'd25;
    localparam logic [CNT_CFG_W-1:0] CAND_CNT_MAX  = 7'd64;

    typedef struct packed {
        logic [PEAK_BIN_W-1:0]     peak_bin;
        logic signed [PHASE_W-1:0] peak_phase;
        logic signed [D15_W-1:0]   d15;
    } t_frame;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SETUP,
        BK_SEARCH,
        BK_DRAIN,
        BK_FINISH
    } t_back_state;

endpackage

/* hdl/spvp_bin_if.sv */
// ----------------------------------------------------------------------------
// spvp_bin_if
// Spectrum bin channel: magnitude, phase and end-of-frame flag.
// ----------------------------------------------------------------------------
interface spvp_bin_if
    import spvp_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [MAG_W-1:0]          magnitude;
    logic signed [PHASE_W-1:0] phase;
    logic                      last_bin;

    modport source (output valid, magnitude, phase, last_bin, input ready);
    modport sink   (input valid, magnitude, phase, last_bin, output ready);
endinterface

/* hdl/spvp_res_if.sv */
// ----------------------------------------------------------------------------
// spvp_res_if
// Result channel: peak bin, coarse and refined frequency, chosen turn offset.
// ----------------------------------------------------------------------------
interface spvp_res_if
    import spvp_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [PEAK_BIN_W-1:0]     peak_bin;
    logic [COARSE_W-1:0]       coarse_freq_q8;
    logic signed [PHASE_W-1:0] peak_phase;
    logic signed [REF_W-1:0]   refined_freq_q8;
    logic [TURN_W-1:0]         turn_offset;

    modport source (output valid, peak_bin, coarse_freq_q8, peak_phase, refined_freq_q8,
                    turn_offset, input ready);
    modport sink   (input valid, peak_bin, coarse_freq_q8, peak_phase, refined_freq_q8,
                    turn_offset, output ready);
endinterface

/* hdl/spectral_peak_phase_vocoder_pitch.sv */
// ----------------------------------------------------------------------------
// spectral_peak_phase_vocoder_pitch
// Spectral peak pick with phase-vocoder frequency refinement.
//
//   port     dir  word
//   i_bin    in   magnitude, phase, last_bin (one spectrum bin)
//   o_res    out  peak_bin, coarse_freq_q8, peak_phase, refined_freq_q8,
//                 turn_offset (one per frame)
//   i_cfg_*  in   register write: index, data
//
// Bins are taken one per cycle while the two-frame queue has room.
// After a setup state the offset search walks one candidate per cycle
// (count clamped to 1..64); drain and finish states follow, and the word
// is registered in finish. Synchronous reset clears control and tracker
// state, not datapath or queue storage, and restores the register
// defaults. An o_res stall holds the word; i_bin stalls once the queue fills.
// ----------------------------------------------------------------------------
module spectral_peak_phase_vocoder_pitch
    import spvp_pkg::*;
#(
    parameter int XFORM_LEN = XFORM_LEN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    spvp_bin_if.sink             i_bin,
    spvp_res_if.source           o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0]     r_bin_width;
    logic [CFG_W-1:0]     r_hop_rate;
    logic [CNT_CFG_W-1:0] r_cand_cnt;

    logic   w_push;
    logic   w_pop;
    logic   w_full;
    logic   w_empty;
    t_frame w_frame_in;
    t_frame w_frame_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_width <= BIN_WIDTH_RST;
            r_hop_rate  <= HOP_RATE_RST;
            r_cand_cnt  <= CAND_CNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BIN_WIDTH: r_bin_width <= i_cfg_data;
                CFG_HOP_RATE:  r_hop_rate  <= i_cfg_data;
                CFG_CAND_CNT:  r_cand_cnt  <= CNT_CFG_W'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    spvp_front #(
        .XFORM_LEN (XFORM_LEN)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_bin   (i_bin),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_frame (w_frame_in)
    );

    spvp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_frame (w_frame_in),
        .i_pop   (w_pop),
        .o_frame (w_frame_out),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    spvp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_frame     (w_frame_out),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .i_bin_width (r_bin_width),
        .i_hop_rate  (r_hop_rate),
        .i_cand_cnt  (r_cand_cnt),
        .o_res       (o_res)
    );

endmodule

/* hdl/spvp_front.sv */
// ----------------------------------------------------------------------------
// spvp_front
// Peak tracker: follows the first strict magnitude maximum of a frame and
// hands the peak and its phase step to the frame queue at the last bin.
// ----------------------------------------------------------------------------
module spvp_front
    import spvp_pkg::*;
#(
    parameter int XFORM_LEN = XFORM_LEN_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    spvp_bin_if.sink       i_bin,
    input  logic           i_full,
    output logic           o_push,
    output t_frame         o_frame
);

    localparam int BIN_LIMIT = (XFORM_LEN / 2 > 512) ? 512 : XFORM_LEN / 2;
    localparam int CNT_W     = $clog2(BIN_LIMIT + 1);

    logic [MAG_W-1:0]          r_max;
    logic [PEAK_BIN_W-1:0]     r_peak_bin;
    logic signed [PHASE_W-1:0] r_peak_ph;
    logic signed [PHASE_W-1:0] r_prev_ph;
    logic [CNT_W-1:0]          r_bin_cnt;

    logic                      w_take;
    logic                      w_in_range;
    logic                      w_upd;
    logic [PEAK_BIN_W-1:0]     n_peak_bin;
    logic signed [PHASE_W-1:0] n_peak_ph;

    assign i_bin.ready = !i_full;
    assign w_take      = i_bin.valid && !i_full;
    assign w_in_range  = r_bin_cnt < CNT_W'(BIN_LIMIT);
    assign w_upd       = w_in_range && ((r_bin_cnt == '0) || (i_bin.magnitude > r_max));
    assign n_peak_bin  = w_upd ? PEAK_BIN_W'(r_bin_cnt) : r_peak_bin;
    assign n_peak_ph   = w_upd ? i_bin.phase : r_peak_ph;

    assign o_push             = w_take && i_bin.last_bin;
    assign o_frame.peak_bin   = n_peak_bin;
    assign o_frame.peak_phase = n_peak_ph;
    assign o_frame.d15        = D15_W'(n_peak_ph) - D15_W'(r_prev_ph);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max      <= '0;
            r_peak_bin <= '0;
            r_peak_ph  <= '0;
            r_prev_ph  <= '0;
            r_bin_cnt  <= '0;
        end else if (w_take) begin
            if (i_bin.last_bin) begin
                r_prev_ph  <= n_peak_ph;
                r_max      <= '0;
                r_peak_bin <= '0;
                r_peak_ph  <= '0;
                r_bin_cnt  <= '0;
            end else begin
                if (w_upd) begin
                    r_max <= i_bin.magnitude;
                end
                r_peak_bin <= n_peak_bin;
                r_peak_ph  <= n_peak_ph;
                if (w_in_range) begin
                    r_bin_cnt <= r_bin_cnt + 1'b1;
                end
            end
        end
    end

endmodule

/* hdl/spvp_fifo.sv */
// ----------------------------------------------------------------------------
// spvp_fifo
// Short frame queue between the peak tracker and the offset search.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spvp_fifo
    import spvp_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_frame i_frame,
    input  logic   i_pop,
    output t_frame o_frame,
    output logic   o_full,
    output logic   o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_frame           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = r_cnt == CNT_W'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_frame = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    `SPVP_ASSERT(a_no_overflow, i_clk, i_rst_n, i_push |-> !o_full, "frame pushed into full queue")
    `SPVP_ASSERT(a_no_underflow, i_clk, i_rst_n, i_pop |-> !o_empty, "pop from empty queue")
    `SPVP_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CNT_W'(DEPTH), "queue count out of range")

endmodule

/* hdl/spvp_back.sv */
// ----------------------------------------------------------------------------
// spvp_back
// Offset search: forms the coarse frequency, walks the whole-turn offsets one
// per cycle, keeps the nearest estimate, rounds, saturates and holds the word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spvp_back
    import spvp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_frame               i_frame,
    input  logic                 i_empty,
    output logic                 o_pop,
    input  logic [CFG_W-1:0]     i_bin_width,
    input  logic [CFG_W-1:0]     i_hop_rate,
    input  logic [CNT_CFG_W-1:0] i_cand_cnt,
    spvp_res_if.source           o_res
);

    localparam logic signed [EST_W-1:0] RND_HALF = EST_W'(16384);

    t_back_state r_state;
    t_back_state n_state;

    t_frame                  r_frame;
    logic [COARSE_W-1:0]     r_coarse;
    logic signed [EST_W-1:0] r_est;
    logic [TURN_W-1:0]       r_k;
    logic [TURN_W-1:0]       r_k_last;

    logic                    r_cand_vld;
    logic [EST_W-1:0]        r_dist;
    logic [TURN_W-1:0]       r_cand_k;
    logic signed [EST_W-1:0] r_cand_est;

    logic [EST_W-1:0]        r_best;
    logic [TURN_W-1:0]       r_best_k;
    logic signed [EST_W-1:0] r_best_est;

    logic                      r_out_vld;
    logic [PEAK_BIN_W-1:0]     r_out_bin;
    logic [COARSE_W-1:0]       r_out_coarse;
    logic signed [PHASE_W-1:0] r_out_ph;
    logic signed [REF_W-1:0]   r_out_ref;
    logic [TURN_W-1:0]         r_out_k;

    logic                          w_load;
    logic                          w_search;
    logic [COARSE_W-1:0]           w_coarse;
    logic signed [D15_W+CFG_W:0]   w_prod0;
    logic signed [EST_W-1:0]       w_est0;
    logic signed [EST_W-1:0]       w_step;
    logic signed [EST_W-1:0]       w_target;
    logic signed [EST_W:0]         w_diff;
    logic [EST_W-1:0]              w_dist;
    logic [TURN_W-1:0]             w_k_last;
    logic signed [RND_W-1:0]       w_rnd;
    logic signed [RND_W-1:0]       w_sat;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        w_load   = 1'b0;
        w_search = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = BK_SETUP;
                end
            end
            BK_SETUP: begin
                n_state = BK_SEARCH;
            end
            BK_SEARCH: begin
                w_search = 1'b1;
                if (r_k == r_k_last) begin
                    n_state = BK_DRAIN;
                end
            end
            BK_DRAIN: begin
                n_state = BK_FINISH;
            end
            BK_FINISH: begin
                if (!r_out_vld || o_res.ready) begin
                    w_load  = 1'b1;
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    assign w_coarse = COARSE_W'(r_frame.peak_bin) * COARSE_W'(i_bin_width);
    assign w_prod0  = $signed(r_frame.d15) * $signed({1'b0, i_hop_rate});
    assign w_est0   = EST_W'(w_prod0);
    assign w_step   = $signed(EST_W'({i_hop_rate, 15'b0}));
    assign w_target = $signed({1'b0, r_coarse, 15'b0});
    assign w_diff   = (EST_W + 1)'(w_target) - (EST_W + 1)'(r_est);
    assign w_dist   = w_diff[EST_W] ? EST_W'(-w_diff) : EST_W'(w_diff);

    always_comb begin
        if (i_cand_cnt == '0) begin
            w_k_last = '0;
        end else if (i_cand_cnt > CAND_CNT_MAX) begin
            w_k_last = TURN_W'(CAND_CNT_MAX - 1'b1);
        end else begin
            w_k_last = TURN_W'(i_cand_cnt - 1'b1);
        end
    end

    // round half up, then clamp
    assign w_rnd = RND_W'((r_best_est + RND_HALF) >>> 15);
    always_comb begin
        if (w_rnd < REF_MIN) begin
            w_sat = REF_MIN;
        end else if (w_rnd > REF_MAX) begin
            w_sat = REF_MAX;
        end else begin
            w_sat = w_rnd;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_frame <= i_frame;
        end
        if (r_state == BK_SETUP) begin
            r_coarse <= w_coarse;
            r_est    <= w_est0;
            r_k      <= '0;
            r_k_last <= w_k_last;
        end else if (w_search) begin
            r_est <= r_est + w_step;
            r_k   <= r_k + 1'b1;
        end
        if (w_search) begin
            r_dist     <= w_dist;
            r_cand_k   <= r_k;
            r_cand_est <= r_est;
        end
        if (r_cand_vld && ((r_cand_k == '0) || (r_dist < r_best))) begin
            r_best     <= r_dist;
            r_best_k   <= r_cand_k;
            r_best_est <= r_cand_est;
        end
        if (w_load) begin
            r_out_bin    <= r_frame.peak_bin;
            r_out_coarse <= r_coarse;
            r_out_ph     <= r_frame.peak_phase;
            r_out_ref    <= REF_W'(w_sat);
            r_out_k      <= r_best_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_cand_vld <= w_search;
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_res.valid           = r_out_vld;
    assign o_res.peak_bin        = r_out_bin;
    assign o_res.coarse_freq_q8  = r_out_coarse;
    assign o_res.peak_phase      = r_out_ph;
    assign o_res.refined_freq_q8 = r_out_ref;
    assign o_res.turn_offset     = r_out_k;

    `SPVP_ASSERT(a_k_bound, i_clk, i_rst_n,
                 (r_state == BK_SEARCH) |-> (r_k <= r_k_last), "offset index past last candidate")
    `SPVP_ASSERT(a_best_bound, i_clk, i_rst_n,
                 (r_state == BK_FINISH) |-> (r_best_k <= r_k_last), "chosen offset out of range")
    `SPVP_ASSERT_NEXT(a_load_out, i_clk, i_rst_n,
                      w_load, r_out_vld && (r_state == BK_IDLE), "result word not presented")

endmodule

/* tb/spectral_peak_phase_vocoder_pitch_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectral_peak_phase_vocoder_pitch_tb
// Self-checking bench for the spectral peak / phase-vocoder pitch estimator.
// A table of directed bins is sent first, then random frames under several
// register settings. Each accepted bin is run through a local peak tracker
// and offset search. Each result word is compared with the oldest estimate
// still waiting. Both channels idle at random.
// ----------------------------------------------------------------------------
module spectral_peak_phase_vocoder_pitch_tb;
    import spvp_pkg::*;

    localparam int BIN_LIMIT    = (XFORM_LEN_DEF / 2 > 512) ? 512 : XFORM_LEN_DEF / 2;
    localparam int SETTLE       = 100;
    localparam int IDLE_LIMIT   = 4000;
    localparam int PHASE_ITEMS  = 40;
    localparam int PHASE_FRAMES = 5;
    localparam int MAX_REPORTS  = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [PEAK_BIN_W-1:0]     peak_bin;
        logic [COARSE_W-1:0]       coarse_freq_q8;
        logic signed [PHASE_W-1:0] peak_phase;
        logic signed [REF_W-1:0]   refined_freq_q8;
        logic [TURN_W-1:0]         turn_offset;
    } t_freq_word;

    typedef struct packed {
        logic [MAG_W-1:0]          magnitude;
        logic signed [PHASE_W-1:0] phase;
        logic                      last_bin;
        logic                      fixed;
        t_freq_word                want;
    } t_bin_row;

    typedef enum int {
        MAG_RANDOM,
        MAG_TIES,
        MAG_ZERO,
        MAG_RAMP,
        MAG_EXTREME
    } t_mag_style;

    localparam t_freq_word NO_WORD = '0;

    localparam t_bin_row DIRECTED [17] = '{
        // first frame after reset: everything zero
        '{32'h0000_0000, 16'sh0000, 1'b1, 1'b1, '{9'd0, 25'd0, 16'sd0, 24'sd0, 6'd0}},
        // all-zero magnitudes: peak and phase from bin 0
        '{32'h0000_0000, 16'sh7fff, 1'b0, 1'b0, NO_WORD},
        '{32'h0000_0000, 16'sh8000, 1'b0, 1'b0, NO_WORD},
        '{32'h0000_0000, 16'sh0000, 1'b1, 1'b0, NO_WORD},
        // largest negative then largest positive phase step
        '{32'hffff_ffff, 16'sh8000, 1'b1, 1'b0, NO_WORD},
        '{32'h0000_0007, 16'sh7fff, 1'b1, 1'b0, NO_WORD},
        // first strict maximum wins
        '{32'h0000_0001, 16'sh0000, 1'b0, 1'b0, NO_WORD},
        '{32'h0000_0005, 16'sh7fff, 1'b0, 1'b0, NO_WORD},
        '{32'h0000_0005, 16'sh1234, 1'b0, 1'b0, NO_WORD},
        '{32'hffff_ffff, 16'sh0001, 1'b0, 1'b0, NO_WORD},
        '{32'hffff_ffff, 16'sh0002, 1'b1, 1'b0, NO_WORD},
        // equal magnitudes
        '{32'h0000_0009, 16'sh4000, 1'b0, 1'b0, NO_WORD},
        '{32'h0000_0009, 16'shc000, 1'b0, 1'b0, NO_WORD},
        '{32'h0000_0009, 16'sh0100, 1'b1, 1'b0, NO_WORD},
        // rising: peak on the last bin
        '{32'h0000_0001, 16'sh2000, 1'b0, 1'b0, NO_WORD},
        '{32'h0000_0002, 16'sh9000, 1'b0, 1'b0, NO_WORD},
        '{32'h0000_0003, 16'sh6000, 1'b1, 1'b0, NO_WORD}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    spvp_bin_if bin_if ();
    spvp_res_if res_if ();

    spectral_peak_phase_vocoder_pitch u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_bin      (bin_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // register mirror
    logic [CFG_W-1:0]          m_bin_width;
    logic [CFG_W-1:0]          m_hop_rate;
    logic [CNT_CFG_W-1:0]      m_cand_cnt;
    // peak tracker state
    logic [MAG_W-1:0]          pk_max;
    logic [PEAK_BIN_W-1:0]     pk_bin;
    int                        pk_count;
    logic signed [PHASE_W-1:0] pk_phase;
    logic signed [PHASE_W-1:0] prev_phase;

    t_freq_word estimate_q[$];
    int         errors = 0;
    int         idle_cycles = 0;
    bit         no_idle = 1'b0;

    // peak tracking per bin; offset search and rounding at the end of a frame
    function automatic bit peak_refine_step(input logic [MAG_W-1:0] mag,
                                            input logic signed [PHASE_W-1:0] ph,
                                            input logic last,
                                            output t_freq_word word);
        longint coarse;
        longint target;
        longint d15;
        longint hop;
        longint est;
        longint diff;
        longint err_abs;
        longint best;
        longint refined;
        int     count;
        int     best_k;
        int     k;
        word = '0;
        if (pk_count < BIN_LIMIT) begin
            if (pk_count == 0 || mag > pk_max) begin
                pk_max   = mag;
                pk_bin   = pk_count[PEAK_BIN_W-1:0];
                pk_phase = ph;
            end
            pk_count++;
        end
        if (!last) return 1'b0;

        coarse = longint'(pk_bin) * longint'(m_bin_width);
        target = coarse * 32768;
        d15    = longint'(pk_phase) - longint'(prev_phase);
        hop    = longint'(m_hop_rate);
        if (m_cand_cnt == '0) count = 1;
        else if (m_cand_cnt > CAND_CNT_MAX) count = int'(CAND_CNT_MAX);
        else count = int'(m_cand_cnt);
        best   = 0;
        best_k = 0;
        for (k = 0; k < count; k++) begin
            est     = (d15 + longint'(k) * 32768) * hop;
            diff    = target - est;
            err_abs = (diff < 0) ? -diff : diff;
            if (k == 0 || err_abs < best) begin
                best   = err_abs;
                best_k = k;
            end
        end
        // floor of (x + half) / 2^15: nearest, ties upwards
        refined = ((d15 + longint'(best_k) * 32768) * hop + 16384) >>> 15;
        if (refined < longint'(REF_MIN)) refined = longint'(REF_MIN);
        if (refined > longint'(REF_MAX)) refined = longint'(REF_MAX);

        word.peak_bin        = pk_bin;
        word.coarse_freq_q8  = coarse[COARSE_W-1:0];
        word.peak_phase      = pk_phase;
        word.refined_freq_q8 = refined[REF_W-1:0];
        word.turn_offset     = best_k[TURN_W-1:0];

        prev_phase = pk_phase;
        pk_max     = '0;
        pk_bin     = '0;
        pk_phase   = '0;
        pk_count   = 0;
        return 1'b1;
    endfunction

    task automatic flag_error(input bit have_want, input t_freq_word want,
                              input t_freq_word got);
        if (errors < MAX_REPORTS) begin
            if (have_want)
                $display("%0t mismatch: expected bin %0d coarse %0d phase %0d refined %0d turn %0d",
                         $realtime, want.peak_bin, want.coarse_freq_q8, want.peak_phase,
                         want.refined_freq_q8, want.turn_offset);
            else
                $display("%0t unexpected word, none outstanding", $realtime);
            $display("%0t          got: bin %0d coarse %0d phase %0d refined %0d turn %0d",
                     $realtime, got.peak_bin, got.coarse_freq_q8, got.peak_phase,
                     got.refined_freq_q8, got.turn_offset);
        end
        errors++;
    endtask

    task automatic send_bin(input logic [MAG_W-1:0] mag, input logic signed [PHASE_W-1:0] ph,
                            input logic last, input logic fixed, input t_freq_word want);
        int         gap;
        t_freq_word word;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            bin_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        bin_if.valid     <= 1'b1;
        bin_if.magnitude <= mag;
        bin_if.phase     <= ph;
        bin_if.last_bin  <= last;
        do @(posedge i_clk); while (!bin_if.ready);
        if (peak_refine_step(mag, ph, last, word))
            estimate_q.push_back(fixed ? want : word);
    endtask

    task automatic send_frame(input int len, input t_mag_style style);
        logic [MAG_W-1:0]          mag;
        logic signed [PHASE_W-1:0] ph;
        int                        i;
        for (i = 0; i < len; i++) begin
            case (style)
                MAG_RANDOM: mag = $urandom;
                MAG_TIES:   mag = MAG_W'($urandom_range(0, 3));
                MAG_ZERO:   mag = '0;
                MAG_RAMP:   mag = MAG_W'(i);
                default:    mag = $urandom_range(0, 1) ? '1 : '0;
            endcase
            case ($urandom_range(0, 7))
                0:       ph = 16'sh7fff;
                1:       ph = 16'sh8000;
                default: ph = PHASE_W'($urandom);
            endcase
            send_bin(mag, ph, i == len - 1, 1'b0, NO_WORD);
        end
    endtask

    task automatic run_random_phase(input bit with_long);
        int items;
        int frames;
        int len;
        items  = 0;
        frames = 0;
        // overlong frame: peak lands on the last tracked bin, the rest is ignored
        if (with_long) send_frame(BIN_LIMIT + $urandom_range(0, 16), MAG_RAMP);
        while (items < PHASE_ITEMS || frames < PHASE_FRAMES) begin
            no_idle = ($urandom_range(0, 3) == 0);
            len     = $urandom_range(1, 16);
            send_frame(len, t_mag_style'($urandom_range(0, 4)));
            items += len;
            frames++;
        end
    endtask

    task automatic wait_drained();
        bin_if.valid <= 1'b0;
        while (estimate_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_BIN_WIDTH: m_bin_width = data;
            CFG_HOP_RATE:  m_hop_rate  = data;
            CFG_CAND_CNT:  m_cand_cnt  = data[CNT_CFG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [CFG_W-1:0] width, input logic [CFG_W-1:0] hop,
                            input logic [CFG_W-1:0] cnt);
        wait_drained();
        write_reg(CFG_BIN_WIDTH, width);
        write_reg(CFG_HOP_RATE, hop);
        write_reg(CFG_CAND_CNT, cnt);
        write_reg(CFG_SPARE, CFG_W'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        int i;
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= '0;
        i_cfg_data       <= '0;
        bin_if.valid     <= 1'b0;
        bin_if.magnitude <= '0;
        bin_if.phase     <= '0;
        bin_if.last_bin  <= 1'b0;
        m_bin_width = BIN_WIDTH_RST;
        m_hop_rate  = HOP_RATE_RST;
        m_cand_cnt  = CAND_CNT_RST;
        pk_max      = '0;
        pk_bin      = '0;
        pk_count    = 0;
        pk_phase    = '0;
        prev_phase  = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < $size(DIRECTED); i++)
            send_bin(DIRECTED[i].magnitude, DIRECTED[i].phase, DIRECTED[i].last_bin,
                     DIRECTED[i].fixed, DIRECTED[i].want);

        set_regs(16'hffff, 16'hffff, 16'd64);
        run_random_phase(1'b1);
        set_regs(16'h0000, 16'h0000, 16'h0000);
        run_random_phase(1'b0);
        // count field masked to seven bits: zero, taken as one
        set_regs(16'h0001, 16'hffff, 16'hff80);
        run_random_phase(1'b0);
        set_regs(CFG_W'($urandom), CFG_W'($urandom), 16'h007f);
        run_random_phase(1'b0);
        set_regs(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom_range(1, 64)));
        run_random_phase(1'b0);
        set_regs(BIN_WIDTH_RST, HOP_RATE_RST, CFG_W'($urandom));
        run_random_phase(1'b0);

        wait_drained();
        errors += estimate_q.size();
        if (errors == 0)
            $display("spectral_peak_phase_vocoder_pitch regression: pass");
        else
            $display("spectral_peak_phase_vocoder_pitch regression: fail");
        $finish;
    end

    initial begin : result_sink
        int         stall;
        t_freq_word got;
        t_freq_word want;
        res_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (res_if.valid !== 1'b1);
            got.peak_bin        = res_if.peak_bin;
            got.coarse_freq_q8  = res_if.coarse_freq_q8;
            got.peak_phase      = res_if.peak_phase;
            got.refined_freq_q8 = res_if.refined_freq_q8;
            got.turn_offset     = res_if.turn_offset;
            if (estimate_q.size() == 0) begin
                flag_error(1'b0, NO_WORD, got);
            end else begin
                want = estimate_q.pop_front();
                if (got.peak_bin !== want.peak_bin
                    || got.coarse_freq_q8 !== want.coarse_freq_q8
                    || got.peak_phase !== want.peak_phase
                    || got.refined_freq_q8 !== want.refined_freq_q8
                    || got.turn_offset !== want.turn_offset)
                    flag_error(1'b1, want, got);
            end
        end
    end

    // no word moving on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (bin_if.valid && bin_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("spectral_peak_phase_vocoder_pitch regression: fail");
            $finish;
        end
    end

endmodule
